// ===== src/at_rsp_pkg.sv =====
// Shared constants for the AT command response parser.
package at_rsp_pkg;

  // Default store geometry
  localparam int unsigned MaxLinesDef = 16;
  localparam int unsigned LineLenDef  = 64;

  // Characters recognized by the parser
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChK     = 8'h4B;
  localparam logic [7:0] ChR     = 8'h52;

  // Result status codes
  localparam logic [1:0] StatMore  = 2'd0;
  localparam logic [1:0] StatOk    = 2'd1;
  localparam logic [1:0] StatError = 2'd2;

  // Command codes carried in tuser
  localparam logic CmdFeed = 1'b0;
  localparam logic CmdRead = 1'b1;

endpackage

// ===== src/at_response_parser_core.sv =====
// AT command response parser: byte-serial state machine with a line text store.
//
// Input beats on the s_axis channel carry a command in tuser: feed rx_byte to
// the parser, or read one stored character at line_sel / col_sel. Every input
// beat produces exactly one output beat on m_axis with the status, the OK
// flag, the stored line count, the read character and the overflow flag.
// A new beat is taken every cycle while the receiver keeps up. Each accepted
// beat is registered in the result stage, together with the registered read of
// the line store memory, then enters the output queue feeding m_axis. The parser
// state and counters sit in flops, the line text in a single-port-write,
// one-read synchronous memory. A 2-entry output queue follows the memory read
// stage and holds the beat still in flight when the receiver stalls. tready is
// high only while at most one result would be queued or in flight after this
// cycle's output beat, so in steady flow it drops in the first stall cycle and
// rises again in the cycle the receiver takes a beat. Reset returns the parser
// to the start state and clears the line count, flags and all valid state; the
// text memory is not cleared and reads of never-written entries return
// undefined data.
module at_response_parser_core #(
  parameter int unsigned MAX_LINES = at_rsp_pkg::MaxLinesDef,
  parameter int unsigned LINE_LEN  = at_rsp_pkg::LineLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: rx_byte[7:0], line_sel[11:8], col_sel[17:12], zero fill [23:18]
  input  logic [23:0] s_axis_tdata_i,
  // tuser: command[0]
  input  logic        s_axis_tuser_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: status[1:0], ok_flag[2], lines_stored[7:3], read_char[15:8],
  //        overflow[16], zero fill [23:17]
  output logic [23:0] m_axis_tdata_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i
);

  localparam int unsigned Depth = MAX_LINES * LINE_LEN;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(LINE_LEN);
  localparam int unsigned LTW   = $clog2(MAX_LINES + 1);
  localparam int unsigned RW    = 17;

  // Parser states
  localparam logic [4:0] StStart  = 5'd0;
  localparam logic [4:0] StLf1    = 5'd1;
  localparam logic [4:0] StSel    = 5'd2;
  localparam logic [4:0] StK      = 5'd3;
  localparam logic [4:0] StOkCr   = 5'd4;
  localparam logic [4:0] StOkLf   = 5'd5;
  localparam logic [4:0] StR1     = 5'd6;
  localparam logic [4:0] StR2     = 5'd7;
  localparam logic [4:0] StO      = 5'd8;
  localparam logic [4:0] StR3     = 5'd9;
  localparam logic [4:0] StErCr   = 5'd10;
  localparam logic [4:0] StErLf   = 5'd11;
  localparam logic [4:0] StText   = 5'd12;
  localparam logic [4:0] StTxtLf  = 5'd13;
  localparam logic [4:0] StNext   = 5'd14;
  localparam logic [4:0] StFinLf  = 5'd15;
  localparam logic [4:0] StFinSel = 5'd16;
  localparam logic [4:0] StError  = 5'd17;

  // Input fields
  logic [7:0] rx_byte;
  logic [3:0] line_sel;
  logic [5:0] col_sel;
  logic       command;
  logic       in_fire;

  assign rx_byte  = s_axis_tdata_i[7:0];
  assign line_sel = s_axis_tdata_i[11:8];
  assign col_sel  = s_axis_tdata_i[17:12];
  assign command  = s_axis_tuser_i;
  assign in_fire  = s_axis_tvalid_i & s_axis_tready_o;

  // Parser state
  logic [4:0]     state_q, state_d;
  logic [CW-1:0]  col_q, col_d;
  logic [LTW-1:0] lines_q, lines_d;
  logic           ok_q, ok_d;
  logic           ovf_q, ovf_d;
  logic [1:0]     status_d;

  // Store access
  logic           wr_en;
  logic [7:0]     wr_data;
  logic [AW-1:0]  wr_addr;
  logic           rd_en;
  logic           rd_hit;
  logic [AW-1:0]  rd_addr;
  logic           room;
  logic           col_full;

  assign room     = 32'(lines_q) < MAX_LINES;
  assign col_full = 32'(col_q) >= LINE_LEN - 1;
  assign wr_addr  = AW'(32'(lines_q) * LINE_LEN + 32'(col_q));
  assign rd_hit   = (32'(line_sel) < MAX_LINES) && (32'(col_sel) < LINE_LEN);
  assign rd_addr  = AW'(32'(line_sel) * LINE_LEN + 32'(col_sel));
  assign rd_en    = in_fire && (command == at_rsp_pkg::CmdRead) && rd_hit;

  // Next parser state for a fed byte
  always_comb begin
    state_d  = state_q;
    col_d    = col_q;
    lines_d  = lines_q;
    ok_d     = ok_q;
    ovf_d    = ovf_q;
    status_d = at_rsp_pkg::StatMore;
    wr_en    = 1'b0;
    wr_data  = rx_byte;
    if (in_fire && command == at_rsp_pkg::CmdFeed) begin
      case (state_q)
        StStart: begin
          if (rx_byte == at_rsp_pkg::ChCr) state_d = StLf1;
          else state_d = StError;
        end
        StLf1: begin
          if (rx_byte == at_rsp_pkg::ChLf) state_d = StSel;
          else state_d = StError;
        end
        StSel: begin
          if (rx_byte == at_rsp_pkg::ChO) state_d = StK;
          else if (rx_byte == at_rsp_pkg::ChE) state_d = StR1;
          else if (rx_byte == at_rsp_pkg::ChPlus) state_d = StText;
          else state_d = StError;
        end
        StK: begin
          if (rx_byte == at_rsp_pkg::ChK) state_d = StOkCr;
          else state_d = StError;
        end
        StOkCr: begin
          if (rx_byte == at_rsp_pkg::ChCr) state_d = StOkLf;
          else state_d = StError;
        end
        StOkLf: begin
          if (rx_byte == at_rsp_pkg::ChLf) begin
            ok_d     = 1'b1;
            state_d  = StStart;
            status_d = at_rsp_pkg::StatOk;
          end else begin
            state_d = StError;
          end
        end
        StR1: begin
          if (rx_byte == at_rsp_pkg::ChR) state_d = StR2;
          else state_d = StError;
        end
        StR2: begin
          if (rx_byte == at_rsp_pkg::ChR) state_d = StO;
          else state_d = StError;
        end
        StO: begin
          if (rx_byte == at_rsp_pkg::ChO) state_d = StR3;
          else state_d = StError;
        end
        StR3: begin
          if (rx_byte == at_rsp_pkg::ChR) state_d = StErCr;
          else state_d = StError;
        end
        StErCr: begin
          if (rx_byte == at_rsp_pkg::ChCr) state_d = StErLf;
          else state_d = StError;
        end
        StErLf: begin
          if (rx_byte == at_rsp_pkg::ChLf) begin
            ok_d     = 1'b0;
            state_d  = StStart;
            status_d = at_rsp_pkg::StatError;
          end else begin
            state_d = StError;
          end
        end
        StText: begin
          if (rx_byte != at_rsp_pkg::ChCr) begin
            // Store the character while line and column have room
            if (!room || col_full) ovf_d = 1'b1;
            else wr_en = 1'b1;
            if (!col_full) col_d = col_q + CW'(1);
          end else if (col_q != '0) begin
            // Terminate the line
            wr_en   = room;
            wr_data = 8'h00;
            col_d   = '0;
            state_d = StTxtLf;
          end else begin
            state_d = StError;
          end
        end
        StTxtLf: begin
          if (rx_byte == at_rsp_pkg::ChLf) begin
            if (room) lines_d = lines_q + LTW'(1);
            else ovf_d = 1'b1;
            state_d = StNext;
          end else begin
            state_d = StError;
          end
        end
        StNext: begin
          if (rx_byte == at_rsp_pkg::ChPlus) state_d = StText;
          else if (rx_byte == at_rsp_pkg::ChCr) state_d = StFinLf;
          else state_d = StError;
        end
        StFinLf: begin
          if (rx_byte == at_rsp_pkg::ChLf) state_d = StFinSel;
          else state_d = StError;
        end
        StFinSel: begin
          if (rx_byte == at_rsp_pkg::ChO) state_d = StK;
          else if (rx_byte == at_rsp_pkg::ChE) state_d = StR1;
          else state_d = StError;
        end
        default: begin
          // Error state: consume the byte, report error, restart
          ok_d     = 1'b0;
          state_d  = StStart;
          status_d = at_rsp_pkg::StatError;
        end
      endcase
      // Entering the error state clears the column
      if (state_d == StError) col_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StStart;
      col_q   <= '0;
      lines_q <= '0;
      ok_q    <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      lines_q <= lines_d;
      ok_q    <= ok_d;
      ovf_q   <= ovf_d;
    end
  end

  // Line text store
  logic [7:0] store_mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) store_mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= store_mem[rd_addr];
  end

  // Result stage aligned with the memory read
  logic        p_valid_q;
  logic [1:0]  p_status_q;
  logic        p_ok_q;
  logic [4:0]  p_lines_q;
  logic        p_ovf_q;
  logic        p_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      p_status_q <= status_d;
      p_ok_q     <= ok_d;
      p_lines_q  <= 5'(lines_d);
      p_ovf_q    <= ovf_d;
      p_hit_q    <= rd_en;
    end
  end

  // Output queue, two entries
  logic [RW-1:0] fifo_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          pop;
  logic [RW-1:0] push_data;
  logic [2:0]    fill_next;

  assign pop       = (cnt_q != 2'd0) && m_axis_tready_i;
  assign push_data = {p_ovf_q, (p_hit_q ? rdata_q : 8'h00), p_lines_q, p_ok_q, p_status_q};
  assign fill_next = 3'(cnt_q) + 3'(p_valid_q) - 3'(pop);

  // Accept while the queue can still hold the beat after the one in flight
  assign s_axis_tready_o = fill_next <= 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (p_valid_q) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= 2'(fill_next);
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_valid_q) fifo_q[wr_ptr_q] <= push_data;
  end

  assign m_axis_tvalid_o = cnt_q != 2'd0;
  assign m_axis_tdata_o  = {7'd0, fifo_q[rd_ptr_q]};

endmodule
